### rtl/core/alc_pkg.sv
package alc_pkg;

    localparam int CNT_W      = 16;
    localparam int CFG_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int LUX_W      = 32;
    localparam int RATIO_W    = 7;
    localparam int BAND_W     = 2;
    localparam int SUM_W      = CNT_W + 1;
    localparam int RAT_N_W    = CNT_W + RATIO_W;
    localparam int GAIN_W     = 7;
    localparam int TG_W       = 11;
    localparam int DEN_W      = 22;
    localparam int PROD_W     = 32;
    localparam int DIVD_W     = 2 * LUX_W;
    localparam int FRAC_BITS_DEF = 12;

    localparam logic [RATIO_W-1:0] RatioScale = 7'd100;
    localparam logic [RATIO_W-1:0] RatioZero  = 7'd101;
    localparam logic [RATIO_W-1:0] BandMidMin  = 7'd45;
    localparam logic [RATIO_W-1:0] BandHighMin = 7'd64;
    localparam logic [RATIO_W-1:0] BandIrMin   = 7'd85;
    localparam logic [DEN_W-1:0]   DenUnit     = 22'd5000;

    localparam logic [CFG_W-1:0] IntTimeReset = 3'd1;
    localparam logic [CFG_W-1:0] GainReset    = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INT_TIME = 1'b0,
        REG_GAIN     = 1'b1
    } t_cfg_reg;

    typedef enum logic [BAND_W-1:0] {
        BAND_LOW  = 2'd0,
        BAND_MID  = 2'd1,
        BAND_HIGH = 2'd2,
        BAND_IR   = 2'd3
    } t_band;

    function automatic logic [GAIN_W-1:0] gain_of(input logic [CFG_W-1:0] code);
        logic [GAIN_W-1:0] g;
        case (code)
            3'd0:    g = 7'd1;
            3'd1:    g = 7'd2;
            3'd2:    g = 7'd4;
            3'd3:    g = 7'd8;
            3'd4:    g = 7'd48;
            default: g = 7'd96;
        endcase
        return g;
    endfunction

    // divisor: 50 * (t + 1) * gain * 100
    function automatic logic [DEN_W-1:0] den_of(input logic [CFG_W-1:0] t_code,
                                                input logic [CFG_W-1:0] g_code);
        logic [TG_W-1:0] tg;
        tg = TG_W'(t_code) + TG_W'(1);
        tg = tg * TG_W'(gain_of(g_code));
        return DEN_W'(tg) * DenUnit;
    endfunction

    function automatic t_band band_of(input logic [RATIO_W-1:0] ratio);
        t_band b;
        if (ratio < BandMidMin) begin
            b = BAND_LOW;
        end else if (ratio < BandHighMin) begin
            b = BAND_MID;
        end else if (ratio < BandIrMin) begin
            b = BAND_HIGH;
        end else begin
            b = BAND_IR;
        end
        return b;
    endfunction

    function automatic logic [CNT_W-1:0] coef_c0(input t_band b);
        logic [CNT_W-1:0] c;
        case (b)
            BAND_LOW:  c = 16'd17743;
            BAND_MID:  c = 16'd42785;
            BAND_HIGH: c = 16'd5926;
            default:   c = 16'd0;
        endcase
        return c;
    endfunction

    // magnitude of the channel 1 coefficient
    function automatic logic [CNT_W-1:0] coef_c1(input t_band b);
        logic [CNT_W-1:0] c;
        case (b)
            BAND_LOW:  c = 16'd11059;
            BAND_MID:  c = 16'd19548;
            BAND_HIGH: c = 16'd1185;
            default:   c = 16'd0;
        endcase
        return c;
    endfunction

    // channel 1 term is subtracted only where its coefficient is negative
    function automatic logic coef_c1_sub(input t_band b);
        return (b == BAND_MID);
    endfunction

endpackage

### rtl/core/ambient_light_lux_calc.sv
// Two-channel ambient light lux calculation.
// Input channel: i_valid / o_ready carry one pair of raw counts per item
// (i_count_visible_ir, i_count_ir). Output channel: o_valid / i_ready carry
// o_lux_fixed (unsigned, FRAC_BITS fraction bits), o_ir_ratio and
// o_coeff_band, one result item per input item, in order.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0: integration time code, 1: gain code); write only while idle.
// Pipeline: the ratio divider is a row of 7 one-bit cells, the lux divider
// a row of 32 one-bit cells, plus six registered stages for sum, coefficient
// select, products and output.
// Throughput: one item per cycle while o_ready is high; all stages advance together.
// Reset clears every valid bit and loads the registers with integration
// code 1 and gain code 0; o_ready is high right after reset.
// When the receiver stalls, the held result stays on the output and one more
// item lands in a skid register; only then does o_ready drop, and the whole
// pipeline holds until the output is taken.
module ambient_light_lux_calc
    import alc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CNT_W-1:0]     i_count_visible_ir,
    input  logic [CNT_W-1:0]     i_count_ir,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [LUX_W-1:0]     o_lux_fixed,
    output logic [RATIO_W-1:0]   o_ir_ratio,
    output logic [BAND_W-1:0]    o_coeff_band
);

    localparam int RAT_SIDE_W = 1 + 2 * CNT_W;
    localparam int LUX_SIDE_W = 1 + RATIO_W + BAND_W;
    localparam int RES_W      = LUX_W + RATIO_W + BAND_W;

    logic en;

    logic [CFG_W-1:0] r_int_time;
    logic [CFG_W-1:0] r_gain;
    logic [DEN_W-1:0] r_den;

    logic             r_a_valid;
    logic [CNT_W-1:0] r_a_ch0;
    logic [CNT_W-1:0] r_a_ch1;

    logic               r_b_valid;
    logic [SUM_W-1:0]   r_b_sum;
    logic [RAT_N_W-1:0] r_b_n100;
    logic [CNT_W-1:0]   r_b_ch0;
    logic [CNT_W-1:0]   r_b_ch1;

    logic                  rc_valid;
    logic [RATIO_W-1:0]    rc_quo;
    logic [RAT_SIDE_W-1:0] rc_side;
    logic [RATIO_W-1:0]    ratio_c;

    logic               r_c_valid;
    logic [RATIO_W-1:0] r_c_ratio;
    t_band              r_c_band;
    logic [CNT_W-1:0]   r_c_ch0;
    logic [CNT_W-1:0]   r_c_ch1;

    logic               r_d_valid;
    logic [RATIO_W-1:0] r_d_ratio;
    t_band              r_d_band;
    logic [PROD_W-1:0]  r_d_p0;
    logic [PROD_W-1:0]  r_d_p1;
    logic               r_d_sub;

    logic [PROD_W:0]    num_s;
    logic               r_e_valid;
    logic [RATIO_W-1:0] r_e_ratio;
    t_band              r_e_band;
    logic [PROD_W-1:0]  r_e_num;

    logic [DIVD_W-1:0]     dividend;
    logic [LUX_W-1:0]      div_hi;
    logic                  ovf;
    logic                  lc_valid;
    logic [LUX_W-1:0]      lc_quo;
    logic [LUX_SIDE_W-1:0] lc_side;
    logic [RES_W-1:0]      res_new;

    logic             r_out_valid;
    logic [RES_W-1:0] r_out;
    logic             r_skid_valid;
    logic [RES_W-1:0] r_skid;
    logic             take;

    assign en      = !r_skid_valid;
    assign o_ready = en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_time <= IntTimeReset;
            r_gain     <= GainReset;
            r_den      <= den_of(IntTimeReset, GainReset);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_INT_TIME: r_int_time <= i_cfg_data;
                    REG_GAIN:     r_gain     <= i_cfg_data;
                    default:      ;
                endcase
            end
            r_den <= den_of(r_int_time, r_gain);
        end
    end

    // valid bits of the plain stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= rc_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    // input capture, sum and scaled ir count
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ch0  <= i_count_visible_ir;
            r_a_ch1  <= i_count_ir;
            r_b_sum  <= SUM_W'(r_a_ch0) + SUM_W'(r_a_ch1);
            r_b_n100 <= RAT_N_W'(r_a_ch1) * RAT_N_W'(RatioScale);
            r_b_ch0  <= r_a_ch0;
            r_b_ch1  <= r_a_ch1;
        end
    end

    alc_div_chain #(
        .REM_W  (SUM_W),
        .Q_W    (RATIO_W),
        .SIDE_W (RAT_SIDE_W)
    ) u_ratio_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_valid),
        .i_rem   ({1'b0, r_b_n100[RAT_N_W-1:RATIO_W]}),
        .i_div   (r_b_sum),
        .i_low   (r_b_n100[RATIO_W-1:0]),
        .i_side  ({(r_b_sum == '0), r_b_ch0, r_b_ch1}),
        .o_valid (rc_valid),
        .o_quo   (rc_quo),
        .o_side  (rc_side)
    );

    assign ratio_c = rc_side[RAT_SIDE_W-1] ? RatioZero : rc_quo;

    // band select, products, signed combine
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_ratio <= ratio_c;
            r_c_band  <= band_of(ratio_c);
            r_c_ch0   <= rc_side[2*CNT_W-1:CNT_W];
            r_c_ch1   <= rc_side[CNT_W-1:0];

            r_d_ratio <= r_c_ratio;
            r_d_band  <= r_c_band;
            r_d_p0    <= PROD_W'(r_c_ch0) * PROD_W'(coef_c0(r_c_band));
            r_d_p1    <= PROD_W'(r_c_ch1) * PROD_W'(coef_c1(r_c_band));
            r_d_sub   <= coef_c1_sub(r_c_band);

            r_e_ratio <= r_d_ratio;
            r_e_band  <= r_d_band;
            r_e_num   <= num_s[PROD_W] ? '0 : num_s[PROD_W-1:0];
        end
    end

    assign num_s = r_d_sub ? ({1'b0, r_d_p0} - {1'b0, r_d_p1})
                           : ({1'b0, r_d_p0} + {1'b0, r_d_p1});

    // scaled numerator split into the part below and above the quotient range
    assign dividend = DIVD_W'(r_e_num) << FRAC_BITS;
    assign div_hi   = dividend[DIVD_W-1:LUX_W];
    assign ovf      = (div_hi >= LUX_W'(r_den));

    alc_div_chain #(
        .REM_W  (DEN_W),
        .Q_W    (LUX_W),
        .SIDE_W (LUX_SIDE_W)
    ) u_lux_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_e_valid),
        .i_rem   (div_hi[DEN_W-1:0]),
        .i_div   (r_den),
        .i_low   (dividend[LUX_W-1:0]),
        .i_side  ({ovf, r_e_ratio, r_e_band}),
        .o_valid (lc_valid),
        .o_quo   (lc_quo),
        .o_side  (lc_side)
    );

    assign res_new = {(lc_side[LUX_SIDE_W-1] ? {LUX_W{1'b1}} : lc_quo),
                      lc_side[LUX_SIDE_W-2:0]};

    // output register and skid
    assign take = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (lc_valid) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (lc_valid) begin
            if (!r_out_valid || take) begin
                r_out <= res_new;
            end else begin
                r_skid <= res_new;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_lux_fixed  = r_out[RES_W-1:RATIO_W+BAND_W];
    assign o_ir_ratio   = r_out[RATIO_W+BAND_W-1:BAND_W];
    assign o_coeff_band = r_out[BAND_W-1:0];

endmodule

### rtl/core/alc_div_cell.sv
module alc_div_cell #(
    parameter int REM_W  = 22,
    parameter int LOW_W  = 32,
    parameter int Q_W    = 32,
    parameter int SIDE_W = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [REM_W-1:0]  i_div,
    input  logic [LOW_W-1:0]  i_low,
    input  logic [Q_W-1:0]    i_quo,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [REM_W-1:0]  o_rem,
    output logic [REM_W-1:0]  o_div,
    output logic [LOW_W-1:0]  o_low,
    output logic [Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  r_div;
    logic [LOW_W-1:0]  r_low;
    logic [Q_W-1:0]    r_quo;
    logic [SIDE_W-1:0] r_side;

    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              ge;
    logic [REM_W-1:0]  n_rem;

    // one restoring division step
    assign trial = {i_rem, i_low[LOW_W-1]};
    assign diff  = trial - {1'b0, i_div};
    assign ge    = (trial >= {1'b0, i_div});
    assign n_rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_div  <= i_div;
            r_low  <= {i_low[LOW_W-2:0], 1'b0};
            r_quo  <= {i_quo[Q_W-2:0], ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_low   = r_low;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule

### rtl/core/alc_div_chain.sv
module alc_div_chain #(
    parameter int REM_W  = 22,
    parameter int Q_W    = 32,
    parameter int SIDE_W = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [REM_W-1:0]  i_div,
    input  logic [Q_W-1:0]    i_low,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic [Q_W:0]             vld;
    logic [Q_W:0][REM_W-1:0]  rem;
    logic [Q_W:0][REM_W-1:0]  dvs;
    logic [Q_W:0][Q_W-1:0]    low;
    logic [Q_W:0][Q_W-1:0]    quo;
    logic [Q_W:0][SIDE_W-1:0] side;

    assign vld[0]  = i_valid;
    assign rem[0]  = i_rem;
    assign dvs[0]  = i_div;
    assign low[0]  = i_low;
    assign quo[0]  = '0;
    assign side[0] = i_side;

    for (genvar k = 0; k < Q_W; k++) begin : g_cell
        alc_div_cell #(
            .REM_W  (REM_W),
            .LOW_W  (Q_W),
            .Q_W    (Q_W),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (vld[k]),
            .i_rem   (rem[k]),
            .i_div   (dvs[k]),
            .i_low   (low[k]),
            .i_quo   (quo[k]),
            .i_side  (side[k]),
            .o_valid (vld[k+1]),
            .o_rem   (rem[k+1]),
            .o_div   (dvs[k+1]),
            .o_low   (low[k+1]),
            .o_quo   (quo[k+1]),
            .o_side  (side[k+1])
        );
    end

    assign o_valid = vld[Q_W];
    assign o_quo   = quo[Q_W];
    assign o_side  = side[Q_W];

endmodule

### rtl/core/alc_checker.sv
module alc_checker
    import alc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [CFG_W-1:0]     i_cfg_data,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic [CNT_W-1:0]     i_count_visible_ir,
    input logic [CNT_W-1:0]     i_count_ir,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [LUX_W-1:0]     o_lux_fixed,
    input logic [RATIO_W-1:0]   o_ir_ratio,
    input logic [BAND_W-1:0]    o_coeff_band
);

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid && o_ready)
        else $error("result or stall present right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_lux_fixed)
            && $stable(o_ir_ratio) && $stable(o_coeff_band))
        else $error("stalled item changed");

    a_band_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (o_ir_ratio < BandMidMin && o_coeff_band == BAND_LOW) ||
            (o_ir_ratio >= BandMidMin && o_ir_ratio < BandHighMin
                && o_coeff_band == BAND_MID) ||
            (o_ir_ratio >= BandHighMin && o_ir_ratio < BandIrMin
                && o_coeff_band == BAND_HIGH) ||
            (o_ir_ratio >= BandIrMin && o_ir_ratio <= RatioZero
                && o_coeff_band == BAND_IR))
        else $error("band does not match ratio");

    a_ir_band_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_coeff_band == BAND_IR |-> o_lux_fixed == '0)
        else $error("nonzero lux in top band");

endmodule

bind ambient_light_lux_calc alc_checker u_alc_checker (.*);

### tb/ambient_light_lux_calc_tb.sv
`timescale 1ns / 1ps

module ambient_light_lux_calc_tb
    import alc_pkg::*;
();

    localparam int LUX_FRAC = FRAC_BITS_DEF;
    localparam int MAX_WAIT = 12;
    localparam int DRAIN_CYCLES = 60;
    localparam int N_ROWS = 20;
    localparam int N_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 105;

    typedef struct {
        logic [LUX_W-1:0]   lux;
        logic [RATIO_W-1:0] ratio;
        t_band              band;
    } t_lux_result;

    typedef struct {
        logic [CNT_W-1:0] ch0;
        logic [CNT_W-1:0] ch1;
        bit               typed;
        t_lux_result      res;
    } t_count_row;

    typedef struct {
        logic [CFG_W-1:0] t_code;
        logic [CFG_W-1:0] g_code;
        bit               no_gaps;
    } t_cfg_phase;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_INT_TIME;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [CNT_W-1:0]     i_count_visible_ir = '0;
    logic [CNT_W-1:0]     i_count_ir = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [LUX_W-1:0]     o_lux_fixed;
    logic [RATIO_W-1:0]   o_ir_ratio;
    logic [BAND_W-1:0]    o_coeff_band;

    logic [CFG_W-1:0] cfg_time = IntTimeReset;
    logic [CFG_W-1:0] cfg_gain = GainReset;
    bit               no_gaps = 1'b0;
    bit               failed = 1'b0;
    int               rx_stall = 0;
    t_lux_result      pending_lux[$];

    t_count_row dir_rows [N_ROWS] = '{
        '{16'd0,     16'd0,     1'b1, '{32'd0,         7'd101, BAND_IR}},
        '{16'd0,     16'd65535, 1'b1, '{32'd0,         7'd100, BAND_IR}},
        '{16'd65535, 16'd0,     1'b1, '{32'd476277762, 7'd0,   BAND_LOW}},
        '{16'd0,     16'd1,     1'b1, '{32'd0,         7'd100, BAND_IR}},
        '{16'd15,    16'd85,    1'b1, '{32'd0,         7'd85,  BAND_IR}},
        '{16'd1,     16'd0,     1'b0, '{32'd0, 7'd0, BAND_LOW}},
        '{16'd65535, 16'd65535, 1'b0, '{32'd0, 7'd0, BAND_LOW}},
        '{16'd56,    16'd44,    1'b0, '{32'd0, 7'd0, BAND_LOW}},
        '{16'd55,    16'd45,    1'b0, '{32'd0, 7'd0, BAND_LOW}},
        '{16'd37,    16'd63,    1'b0, '{32'd0, 7'd0, BAND_LOW}},
        '{16'd36,    16'd64,    1'b0, '{32'd0, 7'd0, BAND_LOW}},
        '{16'd16,    16'd84,    1'b0, '{32'd0, 7'd0, BAND_LOW}},
        '{16'd1,     16'd1,     1'b0, '{32'd0, 7'd0, BAND_LOW}},
        '{16'hAAAA,  16'h5555,  1'b0, '{32'd0, 7'd0, BAND_LOW}},
        '{16'h5555,  16'hAAAA,  1'b0, '{32'd0, 7'd0, BAND_LOW}},
        '{16'd65535, 16'd1,     1'b0, '{32'd0, 7'd0, BAND_LOW}},
        '{16'd1,     16'd65535, 1'b0, '{32'd0, 7'd0, BAND_LOW}},
        '{16'd32768, 16'd32767, 1'b0, '{32'd0, 7'd0, BAND_LOW}},
        '{16'd100,   16'd300,   1'b0, '{32'd0, 7'd0, BAND_LOW}},
        '{16'd300,   16'd100,   1'b0, '{32'd0, 7'd0, BAND_LOW}}
    };

    t_cfg_phase phases [N_PHASES] = '{
        '{3'd0, 3'd0, 1'b0},
        '{3'd7, 3'd7, 1'b0},
        '{3'd7, 3'd0, 1'b1},
        '{3'd0, 3'd5, 1'b0},
        '{3'd3, 3'd6, 1'b0},
        '{3'd2, 3'd4, 1'b0},
        '{3'd5, 3'd1, 1'b1},
        '{3'd4, 3'd3, 1'b0},
        '{3'd6, 3'd2, 1'b0}
    };

    ambient_light_lux_calc i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_count_visible_ir (i_count_visible_ir),
        .i_count_ir         (i_count_ir),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_lux_fixed        (o_lux_fixed),
        .o_ir_ratio         (o_ir_ratio),
        .o_coeff_band       (o_coeff_band)
    );

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_lux_result predict_lux(input logic [CNT_W-1:0] ch0,
                                                input logic [CNT_W-1:0] ch1);
        t_lux_result r;
        logic [63:0] sum;
        logic [63:0] gain;
        logic [63:0] den;
        logic [63:0] quot;
        longint      num;
        sum = 64'(ch0) + 64'(ch1);
        if (sum == 0) begin
            r.ratio = RatioZero;
        end else begin
            r.ratio = RATIO_W'((64'(ch1) * 64'd100) / sum);
        end
        if (r.ratio < 7'd45) begin
            r.band = BAND_LOW;
        end else if (r.ratio < 7'd64) begin
            r.band = BAND_MID;
        end else if (r.ratio < 7'd85) begin
            r.band = BAND_HIGH;
        end else begin
            r.band = BAND_IR;
        end
        case (r.band)
            BAND_LOW:  num = longint'(ch0) * 17743 + longint'(ch1) * 11059;
            BAND_MID:  num = longint'(ch0) * 42785 - longint'(ch1) * 19548;
            BAND_HIGH: num = longint'(ch0) * 5926 + longint'(ch1) * 1185;
            default:   num = 0;
        endcase
        case (cfg_gain)
            3'd0:    gain = 64'd1;
            3'd1:    gain = 64'd2;
            3'd2:    gain = 64'd4;
            3'd3:    gain = 64'd8;
            3'd4:    gain = 64'd48;
            default: gain = 64'd96;
        endcase
        den = 64'd50 * (64'(cfg_time) + 64'd1) * gain * 64'd100;
        r.lux = '0;
        if (num > 0) begin
            quot = (64'(num) << LUX_FRAC) / den;
            r.lux = (quot > 64'hFFFF_FFFF) ? '1 : quot[LUX_W-1:0];
        end
        return r;
    endfunction

    task automatic send_counts(input logic [CNT_W-1:0] ch0, input logic [CNT_W-1:0] ch1,
                               input bit typed, input t_lux_result typed_res);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_count_visible_ir <= ch0;
        i_count_ir <= ch1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_lux.push_back(typed ? typed_res : predict_lux(ch0, ch1));
    endtask

    task automatic wait_drained();
        while (pending_lux.size() != 0) @(posedge i_clk);
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_lux.size() == 0) begin
                    $error("result item with nothing expected: lux_fixed %0d", o_lux_fixed);
                    failed = 1'b1;
                end else begin
                    t_lux_result want;
                    want = pending_lux.pop_front();
                    if (o_lux_fixed !== want.lux) begin
                        $error("lux_fixed: expected %0d, got %0d", want.lux, o_lux_fixed);
                        failed = 1'b1;
                    end
                    if (o_ir_ratio !== want.ratio) begin
                        $error("ir_ratio: expected %0d, got %0d", want.ratio, o_ir_ratio);
                        failed = 1'b1;
                    end
                    if (o_coeff_band !== want.band) begin
                        $error("coeff_band: expected %0d, got %0d", want.band, o_coeff_band);
                        failed = 1'b1;
                    end
                end
                rx_stall = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
            end else if (rx_stall > 0) begin
                rx_stall = rx_stall - 1;
            end
            i_ready <= (rx_stall == 0);
        end
    end

    initial begin
        t_lux_result      none;
        logic [CNT_W-1:0] ch0;
        logic [CNT_W-1:0] ch1;
        int               span;
        int               pct;
        none = '{'0, '0, BAND_LOW};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            send_counts(dir_rows[r].ch0, dir_rows[r].ch1, dir_rows[r].typed, dir_rows[r].res);
        end
        i_valid <= 1'b0;

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= REG_INT_TIME;
            i_cfg_data <= phases[p].t_code;
            @(posedge i_clk);
            i_cfg_index <= REG_GAIN;
            i_cfg_data <= phases[p].g_code;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            cfg_time = phases[p].t_code;
            cfg_gain = phases[p].g_code;
            no_gaps = phases[p].no_gaps;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 5))
                    0, 1: begin
                        ch0 = CNT_W'($urandom);
                        ch1 = CNT_W'($urandom);
                    end
                    2: begin
                        ch0 = CNT_W'($urandom_range(0, 200));
                        ch1 = CNT_W'($urandom_range(0, 200));
                    end
                    3: begin
                        // one channel dark
                        ch0 = $urandom_range(0, 1) ? CNT_W'($urandom) : '0;
                        ch1 = (ch0 == 0) ? CNT_W'($urandom) : '0;
                    end
                    default: begin
                        // counts placed near a band edge
                        span = $urandom_range(1, 65535);
                        case ($urandom_range(0, 5))
                            0:       pct = 44;
                            1:       pct = 45;
                            2:       pct = 63;
                            3:       pct = 64;
                            4:       pct = 84;
                            default: pct = 85;
                        endcase
                        ch1 = CNT_W'((span * pct) / 100 + $urandom_range(0, 2));
                        if (ch1 > span) begin
                            ch1 = CNT_W'(span);
                        end
                        ch0 = CNT_W'(span - ch1);
                    end
                endcase
                send_counts(ch0, ch1, 1'b0, none);
            end
            i_valid <= 1'b0;
        end

        no_gaps = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed && pending_lux.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
